/* rtl/stscan_pkg.sv */
// Shared types, token kind codes, character constants and character-class
// functions for the script token scanner. No dependencies.

package stscan_pkg;

  // Default text store size and the widest token length that the range allows.
  localparam int TEXT_BYTES_DEFAULT = 32;
  localparam int TEXT_LEN_W = 6;

  // Depth of the command queue between the scanning front and the emitting back.
  localparam int CMDQ_DEPTH = 2;

  // Token kind codes.
  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_PLUS    = 5'd1;
  localparam logic [4:0] KIND_MINUS   = 5'd2;
  localparam logic [4:0] KIND_STAR    = 5'd3;
  localparam logic [4:0] KIND_SLASH   = 5'd4;
  localparam logic [4:0] KIND_LPAREN  = 5'd5;
  localparam logic [4:0] KIND_RPAREN  = 5'd6;
  localparam logic [4:0] KIND_LBRACE  = 5'd7;
  localparam logic [4:0] KIND_RBRACE  = 5'd8;
  localparam logic [4:0] KIND_SEMI    = 5'd9;
  localparam logic [4:0] KIND_ASSIGN  = 5'd10;
  localparam logic [4:0] KIND_EQ      = 5'd11;
  localparam logic [4:0] KIND_NUMBER  = 5'd12;
  localparam logic [4:0] KIND_STRING  = 5'd13;
  localparam logic [4:0] KIND_IDENT   = 5'd14;
  localparam logic [4:0] KIND_IF      = 5'd15;
  localparam logic [4:0] KIND_ELSE    = 5'd16;
  localparam logic [4:0] KIND_VAR     = 5'd17;
  localparam logic [4:0] KIND_UNKNOWN = 5'd18;

  // ASCII codes used by the scanner.
  localparam logic [7:0] CH_TAB        = 8'd9;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_QUOTE      = 8'd34;
  localparam logic [7:0] CH_LPAREN     = 8'd40;
  localparam logic [7:0] CH_RPAREN     = 8'd41;
  localparam logic [7:0] CH_STAR       = 8'd42;
  localparam logic [7:0] CH_PLUS       = 8'd43;
  localparam logic [7:0] CH_MINUS      = 8'd45;
  localparam logic [7:0] CH_DOT        = 8'd46;
  localparam logic [7:0] CH_SLASH      = 8'd47;
  localparam logic [7:0] CH_ZERO       = 8'd48;
  localparam logic [7:0] CH_NINE       = 8'd57;
  localparam logic [7:0] CH_SEMI       = 8'd59;
  localparam logic [7:0] CH_EQUALS     = 8'd61;
  localparam logic [7:0] CH_QMARK      = 8'd63;
  localparam logic [7:0] CH_UPPER_A    = 8'd65;
  localparam logic [7:0] CH_UPPER_Z    = 8'd90;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;
  localparam logic [7:0] CH_LOWER_A    = 8'd97;
  localparam logic [7:0] CH_LOWER_E    = 8'd101;
  localparam logic [7:0] CH_LOWER_F    = 8'd102;
  localparam logic [7:0] CH_LOWER_I    = 8'd105;
  localparam logic [7:0] CH_LOWER_L    = 8'd108;
  localparam logic [7:0] CH_LOWER_R    = 8'd114;
  localparam logic [7:0] CH_LOWER_S    = 8'd115;
  localparam logic [7:0] CH_LOWER_V    = 8'd118;
  localparam logic [7:0] CH_LOWER_Z    = 8'd122;
  localparam logic [7:0] CH_LBRACE     = 8'd123;
  localparam logic [7:0] CH_RBRACE     = 8'd125;

  // One token to emit: either literal bytes or a run of stored text in one bank.
  typedef struct packed {
    logic                  valid;
    logic [4:0]            kind;
    logic                  stored;
    logic                  bank;
    logic [TEXT_LEN_W-1:0] len;
    logic [7:0]            lit0;
    logic [7:0]            lit1;
  } tok_desc_t;

  // All results of one input item: at most two tokens, in order.
  typedef struct packed {
    tok_desc_t tok0;
    tok_desc_t tok1;
  } scan_cmd_t;

  // Write request into the text store.
  typedef struct packed {
    logic                  valid;
    logic                  bank;
    logic [TEXT_LEN_W-1:0] addr;
    logic [7:0]            data;
  } text_wr_t;

  // Notice that the back has read the last byte of a bank.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
           ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z));
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE);
  endfunction

  // Kind of a single-character operator, or end-of-file code when it is none.
  function automatic logic [4:0] single_kind(input logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_SEMI:   k = KIND_SEMI;
      default:   k = KIND_EOF;
    endcase
    return k;
  endfunction

  // Literal token of up to two bytes.
  function automatic tok_desc_t lit_tok(input logic [4:0] kind, input logic [7:0] b0,
                                        input logic [7:0] b1,
                                        input logic [TEXT_LEN_W-1:0] len);
    tok_desc_t t;
    t.valid  = 1'b1;
    t.kind   = kind;
    t.stored = 1'b0;
    t.bank   = 1'b0;
    t.len    = len;
    t.lit0   = b0;
    t.lit1   = b1;
    return t;
  endfunction

endpackage

/* rtl/stscan_front.sv */
// Scanning front of the token scanner: takes source bytes, tracks the scan
// mode, writes token text into the two-bank text store and queues commands.
// Depends on stscan_pkg.

module stscan_front #(
  parameter int TEXT_BYTES = stscan_pkg::TEXT_BYTES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [7:0]                source_byte,
  input  logic                      end_marker,
  output logic                      full,
  output logic                      cmd_push,
  output stscan_pkg::scan_cmd_t     cmd,
  input  logic                      cmd_full,
  output stscan_pkg::text_wr_t      text_wr,
  input  stscan_pkg::bank_release_t bank_release
);

  localparam int IDX_W = $clog2(TEXT_BYTES);
  localparam logic [IDX_W-1:0] COUNT_LIMIT = IDX_W'(TEXT_BYTES - 1);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_EQ,
    MODE_DOT,
    MODE_NUM,
    MODE_STR,
    MODE_IDENT
  } mode_t;

  // Held request and scan state.
  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic             hold_end;
  mode_t            mode;
  mode_t            mode_next;
  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] count_next;
  logic             bank;
  logic             bank_next;
  logic [1:0]       busy;
  logic [1:0]       busy_next;
  logic [7:0]       head [4];

  // Decision signals for the held request.
  stscan_pkg::tok_desc_t tok0;
  stscan_pkg::tok_desc_t tok1;
  logic                  emit_st;
  logic [4:0]            emit_kind;
  logic                  start;
  logic                  app_more;
  logic                  app_first;
  logic                  wr_req;
  logic [IDX_W-1:0]      wr_idx;
  logic [4:0]            ident_kind;
  logic [4:0]            skind;
  logic                  go;

  // Keyword match on the first stored bytes of an identifier.
  always_comb begin
    ident_kind = stscan_pkg::KIND_IDENT;
    if (7'(count) == 7'd2 && head[0] == stscan_pkg::CH_LOWER_I &&
        head[1] == stscan_pkg::CH_LOWER_F) begin
      ident_kind = stscan_pkg::KIND_IF;
    end else if (7'(count) == 7'd4 && head[0] == stscan_pkg::CH_LOWER_E &&
                 head[1] == stscan_pkg::CH_LOWER_L && head[2] == stscan_pkg::CH_LOWER_S &&
                 head[3] == stscan_pkg::CH_LOWER_E) begin
      ident_kind = stscan_pkg::KIND_ELSE;
    end else if (7'(count) == 7'd3 && head[0] == stscan_pkg::CH_LOWER_V &&
                 head[1] == stscan_pkg::CH_LOWER_A && head[2] == stscan_pkg::CH_LOWER_R) begin
      ident_kind = stscan_pkg::KIND_VAR;
    end
  end

  assign skind = stscan_pkg::single_kind(hold_byte);

  // Classify the held byte against the current mode.
  always_comb begin
    tok0       = '0;
    tok1       = '0;
    emit_st    = 1'b0;
    emit_kind  = stscan_pkg::KIND_EOF;
    start      = 1'b0;
    app_more   = 1'b0;
    app_first  = 1'b0;
    mode_next  = mode;
    count_next = count;
    bank_next  = bank;

    if (hold_end) begin
      unique case (mode)
        MODE_EQ: begin
          tok0 = stscan_pkg::lit_tok(stscan_pkg::KIND_ASSIGN, stscan_pkg::CH_EQUALS, 8'd0, 6'd1);
        end
        MODE_DOT: begin
          tok0 = stscan_pkg::lit_tok(stscan_pkg::KIND_UNKNOWN, stscan_pkg::CH_QMARK, 8'd0, 6'd1);
        end
        MODE_NUM: begin
          emit_st   = 1'b1;
          emit_kind = stscan_pkg::KIND_NUMBER;
        end
        MODE_STR: begin
          emit_st   = 1'b1;
          emit_kind = stscan_pkg::KIND_STRING;
        end
        MODE_IDENT: begin
          emit_st   = 1'b1;
          emit_kind = ident_kind;
        end
        default: begin
        end
      endcase
      tok1       = stscan_pkg::lit_tok(stscan_pkg::KIND_EOF, 8'd0, 8'd0, 6'd0);
      mode_next  = MODE_IDLE;
      count_next = '0;
    end else begin
      unique case (mode)
        MODE_EQ: begin
          if (hold_byte == stscan_pkg::CH_EQUALS) begin
            tok0 = stscan_pkg::lit_tok(stscan_pkg::KIND_EQ, stscan_pkg::CH_EQUALS,
                                       stscan_pkg::CH_EQUALS, 6'd2);
            mode_next = MODE_IDLE;
          end else begin
            tok0 = stscan_pkg::lit_tok(stscan_pkg::KIND_ASSIGN, stscan_pkg::CH_EQUALS,
                                       8'd0, 6'd1);
            start = 1'b1;
          end
        end
        MODE_DOT: begin
          if (stscan_pkg::is_digit(hold_byte)) begin
            app_more  = 1'b1;
            mode_next = MODE_NUM;
          end else begin
            tok0 = stscan_pkg::lit_tok(stscan_pkg::KIND_UNKNOWN, stscan_pkg::CH_QMARK,
                                       8'd0, 6'd1);
            start = 1'b1;
          end
        end
        MODE_NUM: begin
          if (stscan_pkg::is_digit(hold_byte) || hold_byte == stscan_pkg::CH_DOT) begin
            app_more = 1'b1;
          end else begin
            emit_st   = 1'b1;
            emit_kind = stscan_pkg::KIND_NUMBER;
            start     = 1'b1;
          end
        end
        MODE_STR: begin
          if (hold_byte == stscan_pkg::CH_QUOTE) begin
            emit_st   = 1'b1;
            emit_kind = stscan_pkg::KIND_STRING;
            mode_next = MODE_IDLE;
          end else begin
            app_more = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (stscan_pkg::is_word(hold_byte)) begin
            app_more = 1'b1;
          end else begin
            emit_st   = 1'b1;
            emit_kind = ident_kind;
            start     = 1'b1;
          end
        end
        default: begin
          start = 1'b1;
        end
      endcase
    end

    // Finish the pending token that lives in the store.
    if (emit_st) begin
      if (count == '0) begin
        tok0 = stscan_pkg::lit_tok(emit_kind, 8'd0, 8'd0, 6'd0);
      end else begin
        tok0.valid  = 1'b1;
        tok0.kind   = emit_kind;
        tok0.stored = 1'b1;
        tok0.bank   = bank;
        tok0.len    = stscan_pkg::TEXT_LEN_W'(count);
        tok0.lit0   = 8'd0;
        tok0.lit1   = 8'd0;
        bank_next   = ~bank;
      end
      count_next = '0;
    end

    // Append a byte to the token being collected, dropping it past the limit.
    if (app_more && count < COUNT_LIMIT) begin
      count_next = count + 1'b1;
    end

    // Scan the held byte as the start of a new token.
    if (start) begin
      mode_next  = MODE_IDLE;
      count_next = '0;
      if (stscan_pkg::is_space(hold_byte)) begin
        mode_next = MODE_IDLE;
      end else if (skind != stscan_pkg::KIND_EOF) begin
        tok1 = stscan_pkg::lit_tok(skind, hold_byte, 8'd0, 6'd1);
      end else if (hold_byte == stscan_pkg::CH_EQUALS) begin
        mode_next = MODE_EQ;
      end else if (stscan_pkg::is_digit(hold_byte)) begin
        app_first  = 1'b1;
        count_next = IDX_W'(1);
        mode_next  = MODE_NUM;
      end else if (hold_byte == stscan_pkg::CH_DOT) begin
        app_first  = 1'b1;
        count_next = IDX_W'(1);
        mode_next  = MODE_DOT;
      end else if (hold_byte == stscan_pkg::CH_QUOTE) begin
        mode_next = MODE_STR;
      end else if (stscan_pkg::is_alpha(hold_byte) || hold_byte == stscan_pkg::CH_UNDERSCORE) begin
        app_first  = 1'b1;
        count_next = IDX_W'(1);
        mode_next  = MODE_IDENT;
      end else begin
        tok1 = stscan_pkg::lit_tok(stscan_pkg::KIND_UNKNOWN, stscan_pkg::CH_QMARK, 8'd0, 6'd1);
      end
    end
  end

  // A write goes to the bank that holds the token being collected.
  assign wr_req = app_first || (app_more && count < COUNT_LIMIT);
  assign wr_idx = app_first ? '0 : count;

  // The held request proceeds once the queue has room and its bank is free.
  assign go = hold_valid &&
              !((tok0.valid || tok1.valid) && cmd_full) &&
              !(wr_req && busy[bank_next]);
  assign full = hold_valid && !go;

  assign cmd_push  = go && (tok0.valid || tok1.valid);
  assign cmd.tok0  = tok0;
  assign cmd.tok1  = tok1;

  assign text_wr.valid = go && wr_req;
  assign text_wr.bank  = bank_next;
  assign text_wr.addr  = stscan_pkg::TEXT_LEN_W'(wr_idx);
  assign text_wr.data  = hold_byte;

  // Bank ownership: set when a stored token is queued, cleared on release.
  always_comb begin
    busy_next = busy;
    if (bank_release.valid) begin
      busy_next[bank_release.bank] = 1'b0;
    end
    if (cmd_push && tok0.stored) begin
      busy_next[tok0.bank] = 1'b1;
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      mode       <= MODE_IDLE;
      count      <= '0;
      bank       <= 1'b0;
      busy       <= '0;
    end else begin
      if (push && !full) begin
        hold_valid <= 1'b1;
      end else if (go) begin
        hold_valid <= 1'b0;
      end
      if (go) begin
        mode  <= mode_next;
        count <= count_next;
        bank  <= bank_next;
      end
      busy <= busy_next;
    end
  end

  // Held request payload and the shadow of the first text bytes.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      hold_byte <= source_byte;
      hold_end  <= end_marker;
    end
    if (go && wr_req && 7'(wr_idx) < 7'd4) begin
      head[wr_idx[1:0]] <= hold_byte;
    end
  end

`ifndef NO_ASSERTIONS
  // Text is never written into a bank whose token is still being emitted.
  assert property (@(posedge clk) disable iff (rst) text_wr.valid |-> !busy[text_wr.bank])
    else $error("text write into a bank in flight");

  // A stored token is only queued for a bank that is not already in flight.
  assert property (@(posedge clk) disable iff (rst)
                   (cmd_push && tok0.stored) |-> !busy[tok0.bank])
    else $error("stored token queued for a busy bank");
`endif

endmodule

/* rtl/stscan_cmdq.sv */
// Short command queue between the scanning front and the emitting back.
// Depends on stscan_pkg.

module stscan_cmdq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  stscan_pkg::scan_cmd_t wr_cmd,
  output logic                  q_full,
  input  logic                  rd_en,
  output stscan_pkg::scan_cmd_t rd_cmd,
  output logic                  q_empty
);

  localparam int PTR_W = $clog2(stscan_pkg::CMDQ_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(stscan_pkg::CMDQ_DEPTH - 1);
  localparam logic [PTR_W:0]   FILL_MAX = (PTR_W + 1)'(stscan_pkg::CMDQ_DEPTH);

  stscan_pkg::scan_cmd_t entries [stscan_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [PTR_W:0]        fill;
  logic                  do_wr;
  logic                  do_rd;

  assign q_full  = (fill == FILL_MAX);
  assign q_empty = (fill == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_cmd  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

/* rtl/stscan_back.sv */
// Emitting back of the token scanner: owns the two-bank text store, expands
// queued commands into one result per text byte and holds the result register.
// Depends on stscan_pkg.

module stscan_back #(
  parameter int TEXT_BYTES = stscan_pkg::TEXT_BYTES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_empty,
  input  stscan_pkg::scan_cmd_t     cmd,
  output logic                      cmd_pop,
  input  stscan_pkg::text_wr_t      text_wr,
  output stscan_pkg::bank_release_t bank_release,
  output logic [4:0]                token_kind,
  output logic [7:0]                text_byte,
  output logic                      byte_valid,
  output logic [4:0]                text_length,
  output logic                      token_last,
  output logic                      run_last,
  output logic                      empty,
  input  logic                      pop
);

  localparam int IDX_W = $clog2(TEXT_BYTES);

  // Text store, one bank per token in flight.
  logic [7:0] text_mem [2][TEXT_BYTES];

  // Expansion state.
  logic                              gen_busy;
  stscan_pkg::scan_cmd_t             cur;
  logic                              phase;
  logic [stscan_pkg::TEXT_LEN_W-1:0] idx;
  stscan_pkg::tok_desc_t             tok;
  logic                              tok_end;
  logic                              more;
  logic                              advance;

  // Result register.
  logic       out_valid;
  logic [4:0] o_kind;
  logic       o_from_mem;
  logic [7:0] o_lit;
  logic       o_byte_valid;
  logic [4:0] o_len;
  logic       o_tlast;
  logic       o_rlast;
  logic [7:0] rd_data;

  // Current token and position within it.
  assign tok     = phase ? cur.tok1 : cur.tok0;
  assign tok_end = (tok.len == '0) || (idx == tok.len - 1'b1);
  assign more    = !phase && cur.tok1.valid;
  assign advance = gen_busy && (!out_valid || pop);
  assign cmd_pop = !gen_busy && !cmd_empty;

  // Expansion control.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_busy     <= 1'b0;
      bank_release <= '0;
    end else begin
      bank_release.valid <= advance && tok_end && tok.stored;
      bank_release.bank  <= tok.bank;
      if (cmd_pop) begin
        gen_busy <= 1'b1;
      end else if (advance && tok_end && !more) begin
        gen_busy <= 1'b0;
      end
    end
  end

  // Command, token phase and byte position.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur   <= cmd;
      phase <= !cmd.tok0.valid;
      idx   <= '0;
    end else if (advance) begin
      if (tok_end) begin
        phase <= 1'b1;
        idx   <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Text store write and registered read.
  always_ff @(posedge clk) begin
    if (text_wr.valid) begin
      text_mem[text_wr.bank][text_wr.addr[IDX_W-1:0]] <= text_wr.data;
    end
    if (advance) begin
      rd_data <= text_mem[tok.bank][idx[IDX_W-1:0]];
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      o_kind       <= tok.kind;
      o_from_mem   <= tok.stored;
      o_lit        <= (idx == '0) ? tok.lit0 : tok.lit1;
      o_byte_valid <= (tok.len != '0);
      o_len        <= 5'(tok.len);
      o_tlast      <= tok_end;
      o_rlast      <= tok_end && !more;
    end
  end

  assign empty       = !out_valid;
  assign token_kind  = o_kind;
  assign text_byte   = o_from_mem ? rd_data : o_lit;
  assign byte_valid  = o_byte_valid;
  assign text_length = o_len;
  assign token_last  = o_tlast;
  assign run_last    = o_rlast;

`ifndef NO_ASSERTIONS
  // Every queued command carries at least one token.
  assert property (@(posedge clk) disable iff (rst)
                   cmd_pop |-> (cmd.tok0.valid || cmd.tok1.valid))
    else $error("empty command taken from the queue");

  // Stored tokens always have text; empty text is sent as a literal.
  assert property (@(posedge clk) disable iff (rst)
                   cmd_pop |-> !(cmd.tok0.stored && cmd.tok0.len == '0))
    else $error("stored token with no text");

  // The last result of a request always closes a token.
  assert property (@(posedge clk) disable iff (rst) (!empty && run_last) |-> token_last)
    else $error("request ends inside a token");
`endif

endmodule

/* rtl/script_token_scanner_unit.sv */
// Script token scanner: an item is held in the front, classified and queued; its first
// result then passes the command queue and the back's command register to the result register.
// The back emits one result per cycle while the receiver pops, and takes a new queued
// command only after the last one is done; long tokens cost one result per text byte.
// Reset is synchronous and clears all control state; the text store is not cleared.
// Depends on stscan_pkg, stscan_front, stscan_cmdq and stscan_back.

module script_token_scanner_unit #(
  parameter int TEXT_BYTES = stscan_pkg::TEXT_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] source_byte,
  input  logic       end_marker,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] token_kind,
  output logic [7:0] text_byte,
  output logic       byte_valid,
  output logic [4:0] text_length,
  output logic       token_last,
  output logic       run_last
);

  stscan_pkg::scan_cmd_t     push_cmd;
  stscan_pkg::scan_cmd_t     head_cmd;
  logic                      cmd_push;
  logic                      cmd_full;
  logic                      cmd_pop;
  logic                      cmd_empty;
  stscan_pkg::text_wr_t      text_wr;
  stscan_pkg::bank_release_t bank_release;

  // Front: scan mode, text collection and command generation.
  stscan_front #(
    .TEXT_BYTES(TEXT_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .source_byte (source_byte),
    .end_marker  (end_marker),
    .full        (full),
    .cmd_push    (cmd_push),
    .cmd         (push_cmd),
    .cmd_full    (cmd_full),
    .text_wr     (text_wr),
    .bank_release(bank_release)
  );

  // Queue that decouples scanning from emission.
  stscan_cmdq u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_cmd (push_cmd),
    .q_full (cmd_full),
    .rd_en  (cmd_pop),
    .rd_cmd (head_cmd),
    .q_empty(cmd_empty)
  );

  // Back: text store and per-byte result emission.
  stscan_back #(
    .TEXT_BYTES(TEXT_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (cmd_empty),
    .cmd         (head_cmd),
    .cmd_pop     (cmd_pop),
    .text_wr     (text_wr),
    .bank_release(bank_release),
    .token_kind  (token_kind),
    .text_byte   (text_byte),
    .byte_valid  (byte_valid),
    .text_length (text_length),
    .token_last  (token_last),
    .run_last    (run_last),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

/* bench/tb_script_token_scanner_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for script_token_scanner_unit: a directed lexing run, then
// random token streams under several idling patterns and one long output hold-off.
// Depends on stscan_pkg and the script_token_scanner_unit RTL.

module tb_script_token_scanner_unit;

  localparam int TEXT_BYTES     = stscan_pkg::TEXT_BYTES_DEFAULT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;

  // One emitted result, field for field as it appears on the output ports.
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] text;
    logic       valid;
    logic [4:0] len;
    logic       tlast;
    logic       rlast;
  } token_result_t;

  // One source request: a byte or the end of the source.
  typedef struct {
    logic [7:0] b;
    logic       e;
  } source_item_t;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_EQ, SCAN_DOT, SCAN_NUM, SCAN_STR, SCAN_IDENT
  } scan_mode_t;

  // Lexer predictor plus the queue of token bytes still to come out of the block.
  class token_scoreboard;
    token_result_t expected_q[$];
    scan_mode_t    mode;
    logic [7:0]    text_buf[TEXT_BYTES];
    int            text_cnt;
    int            errors;

    function new();
      mode     = SCAN_IDLE;
      text_cnt = 0;
      errors   = 0;
    endfunction

    function bit blank_char(logic [7:0] b);
      return (b == stscan_pkg::CH_SPACE) ||
             ((b >= stscan_pkg::CH_TAB) && (b <= stscan_pkg::CH_CR));
    endfunction

    function bit numeral_char(logic [7:0] b);
      return (b >= stscan_pkg::CH_ZERO) && (b <= stscan_pkg::CH_NINE);
    endfunction

    function bit letter_char(logic [7:0] b);
      return ((b >= stscan_pkg::CH_LOWER_A) && (b <= stscan_pkg::CH_LOWER_Z)) ||
             ((b >= stscan_pkg::CH_UPPER_A) && (b <= stscan_pkg::CH_UPPER_Z));
    endfunction

    function void add_result(logic [4:0] kind, logic [7:0] b, logic v, int len, logic tl);
      token_result_t r;
      r.kind  = kind;
      r.text  = b;
      r.valid = v;
      r.len   = len[4:0];
      r.tlast = tl;
      r.rlast = 1'b0;
      expected_q.push_back(r);
    endfunction

    // Fixed text of one or two bytes, such as an operator or the question mark.
    function void emit_literal(logic [4:0] kind, logic [7:0] b0, logic [7:0] b1, int len);
      if (len == 1) begin
        add_result(kind, b0, 1'b1, 1, 1'b1);
      end else begin
        add_result(kind, b0, 1'b1, 2, 1'b0);
        add_result(kind, b1, 1'b1, 2, 1'b1);
      end
    endfunction

    // Collected text; identifiers are promoted to keywords on an exact match.
    function void emit_text(logic [4:0] kind);
      int         i;
      logic [4:0] k;
      k = kind;
      if (kind == stscan_pkg::KIND_IDENT) begin
        if (text_cnt == 2 && text_buf[0] == stscan_pkg::CH_LOWER_I &&
            text_buf[1] == stscan_pkg::CH_LOWER_F)
          k = stscan_pkg::KIND_IF;
        else if (text_cnt == 4 && text_buf[0] == stscan_pkg::CH_LOWER_E &&
                 text_buf[1] == stscan_pkg::CH_LOWER_L &&
                 text_buf[2] == stscan_pkg::CH_LOWER_S &&
                 text_buf[3] == stscan_pkg::CH_LOWER_E)
          k = stscan_pkg::KIND_ELSE;
        else if (text_cnt == 3 && text_buf[0] == stscan_pkg::CH_LOWER_V &&
                 text_buf[1] == stscan_pkg::CH_LOWER_A &&
                 text_buf[2] == stscan_pkg::CH_LOWER_R)
          k = stscan_pkg::KIND_VAR;
      end
      if (text_cnt == 0) begin
        add_result(k, 8'h00, 1'b0, 0, 1'b1);
      end else begin
        for (i = 0; i < text_cnt; i++)
          add_result(k, text_buf[i], 1'b1, text_cnt, i == text_cnt - 1);
      end
      text_cnt = 0;
      mode     = SCAN_IDLE;
    endfunction

    // Bytes past the last stored slot still belong to the token but are dropped.
    function void keep_byte(logic [7:0] b);
      if (text_cnt < TEXT_BYTES - 1) begin
        text_buf[text_cnt] = b;
        text_cnt++;
      end
    endfunction

    // Scan a byte with no token in progress.
    function void start_token(logic [7:0] b);
      text_cnt = 0;
      mode     = SCAN_IDLE;
      if (blank_char(b))
        return;
      case (b)
        stscan_pkg::CH_PLUS:   emit_literal(stscan_pkg::KIND_PLUS, b, 8'h00, 1);
        stscan_pkg::CH_MINUS:  emit_literal(stscan_pkg::KIND_MINUS, b, 8'h00, 1);
        stscan_pkg::CH_STAR:   emit_literal(stscan_pkg::KIND_STAR, b, 8'h00, 1);
        stscan_pkg::CH_SLASH:  emit_literal(stscan_pkg::KIND_SLASH, b, 8'h00, 1);
        stscan_pkg::CH_LPAREN: emit_literal(stscan_pkg::KIND_LPAREN, b, 8'h00, 1);
        stscan_pkg::CH_RPAREN: emit_literal(stscan_pkg::KIND_RPAREN, b, 8'h00, 1);
        stscan_pkg::CH_LBRACE: emit_literal(stscan_pkg::KIND_LBRACE, b, 8'h00, 1);
        stscan_pkg::CH_RBRACE: emit_literal(stscan_pkg::KIND_RBRACE, b, 8'h00, 1);
        stscan_pkg::CH_SEMI:   emit_literal(stscan_pkg::KIND_SEMI, b, 8'h00, 1);
        stscan_pkg::CH_EQUALS: mode = SCAN_EQ;
        stscan_pkg::CH_QUOTE:  mode = SCAN_STR;
        stscan_pkg::CH_DOT: begin
          keep_byte(b);
          mode = SCAN_DOT;
        end
        default: begin
          if (numeral_char(b)) begin
            keep_byte(b);
            mode = SCAN_NUM;
          end else if (letter_char(b) || b == stscan_pkg::CH_UNDERSCORE) begin
            keep_byte(b);
            mode = SCAN_IDENT;
          end else begin
            emit_literal(stscan_pkg::KIND_UNKNOWN, stscan_pkg::CH_QMARK, 8'h00, 1);
          end
        end
      endcase
    endfunction

    // Work out every result that an accepted request causes.
    function void note_request(logic [7:0] b, logic e);
      int            first_new;
      token_result_t r;
      first_new = expected_q.size();
      if (e) begin
        case (mode)
          SCAN_EQ:    emit_literal(stscan_pkg::KIND_ASSIGN, stscan_pkg::CH_EQUALS, 8'h00, 1);
          SCAN_DOT:   emit_literal(stscan_pkg::KIND_UNKNOWN, stscan_pkg::CH_QMARK, 8'h00, 1);
          SCAN_NUM:   emit_text(stscan_pkg::KIND_NUMBER);
          SCAN_STR:   emit_text(stscan_pkg::KIND_STRING);
          SCAN_IDENT: emit_text(stscan_pkg::KIND_IDENT);
          default: ;
        endcase
        text_cnt = 0;
        mode     = SCAN_IDLE;
        add_result(stscan_pkg::KIND_EOF, 8'h00, 1'b0, 0, 1'b1);
      end else begin
        case (mode)
          SCAN_EQ: begin
            if (b == stscan_pkg::CH_EQUALS) begin
              emit_literal(stscan_pkg::KIND_EQ, stscan_pkg::CH_EQUALS,
                           stscan_pkg::CH_EQUALS, 2);
              mode = SCAN_IDLE;
            end else begin
              emit_literal(stscan_pkg::KIND_ASSIGN, stscan_pkg::CH_EQUALS, 8'h00, 1);
              start_token(b);
            end
          end
          SCAN_DOT: begin
            if (numeral_char(b)) begin
              keep_byte(b);
              mode = SCAN_NUM;
            end else begin
              emit_literal(stscan_pkg::KIND_UNKNOWN, stscan_pkg::CH_QMARK, 8'h00, 1);
              start_token(b);
            end
          end
          SCAN_NUM: begin
            if (numeral_char(b) || b == stscan_pkg::CH_DOT) begin
              keep_byte(b);
            end else begin
              emit_text(stscan_pkg::KIND_NUMBER);
              start_token(b);
            end
          end
          SCAN_STR: begin
            if (b == stscan_pkg::CH_QUOTE)
              emit_text(stscan_pkg::KIND_STRING);
            else
              keep_byte(b);
          end
          SCAN_IDENT: begin
            if (letter_char(b) || numeral_char(b) || b == stscan_pkg::CH_UNDERSCORE) begin
              keep_byte(b);
            end else begin
              emit_text(stscan_pkg::KIND_IDENT);
              start_token(b);
            end
          end
          default: start_token(b);
        endcase
      end
      // The last result of this request carries the run marker.
      if (expected_q.size() > first_new) begin
        r = expected_q.pop_back();
        r.rlast = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare an accepted result with the oldest expectation.
    function void check_result(token_result_t got);
      token_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind %0d byte %0d",
                 $time, got.kind, got.text);
        return;
      end
      want = expected_q.pop_front();
      compare_field("token_kind", want.kind, got.kind);
      compare_field("text_byte", want.text, got.text);
      compare_field("byte_valid", want.valid, got.valid);
      compare_field("text_length", want.len, got.len);
      compare_field("token_last", want.tlast, got.tlast);
      compare_field("run_last", want.rlast, got.rlast);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic [7:0] source_byte;
  logic       end_marker;
  logic       full;
  logic       empty;
  logic       pop;
  logic [4:0] token_kind;
  logic [7:0] text_byte;
  logic       byte_valid;
  logic [4:0] text_length;
  logic       token_last;
  logic       run_last;

  token_scoreboard sb = new();
  source_item_t    source_q[$];
  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  bit              hold_request   = 1'b0;
  int              idle_cycles    = 0;

  script_token_scanner_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .source_byte (source_byte),
    .end_marker  (end_marker),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .token_kind  (token_kind),
    .text_byte   (text_byte),
    .byte_valid  (byte_valid),
    .text_length (text_length),
    .token_last  (token_last),
    .run_last    (run_last)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off counted here when one is requested.
  initial begin
    int            hold_left;
    token_result_t got;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (rst) begin
        pop = 1'b0;
      end else if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(0, 99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (pop && !empty) begin
        got.kind  = token_kind;
        got.text  = text_byte;
        got.valid = byte_valid;
        got.len   = text_length;
        got.tlast = token_last;
        got.rlast = run_last;
        sb.check_result(got);
      end
    end
  end

  // Watchdog: ends the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** script_token_scanner_unit: FAILED **");
        $finish;
      end
    end
  end

  function automatic void queue_byte(logic [7:0] b, logic e);
    source_item_t it;
    it.b = b;
    it.e = e;
    source_q.push_back(it);
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 3))
      0:       return 8'(stscan_pkg::CH_LOWER_A + $urandom_range(0, 25));
      1:       return 8'(stscan_pkg::CH_UPPER_A + $urandom_range(0, 25));
      2:       return 8'(stscan_pkg::CH_ZERO + $urandom_range(0, 9));
      default: return stscan_pkg::CH_UNDERSCORE;
    endcase
  endfunction

  // Mostly short tokens; now and then one longer than the text store holds.
  function automatic int token_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 6);
  endfunction

  // Append one random token, mostly well formed, sometimes noise or a broken one.
  function automatic void queue_token();
    int         pick;
    int         n;
    int         i;
    bit         lead_dot;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      if ($urandom_range(0, 4) == 0)
        queue_byte(stscan_pkg::CH_UNDERSCORE, 1'b0);
      else
        queue_byte(8'(stscan_pkg::CH_LOWER_A + $urandom_range(0, 25)), 1'b0);
      n = token_len();
      for (i = 1; i < n; i++)
        queue_byte(word_char(), 1'b0);
    end else if (pick < 23) begin
      case ($urandom_range(0, 2))
        0: begin
          queue_byte(stscan_pkg::CH_LOWER_I, 1'b0);
          queue_byte(stscan_pkg::CH_LOWER_F, 1'b0);
        end
        1: begin
          queue_byte(stscan_pkg::CH_LOWER_E, 1'b0);
          queue_byte(stscan_pkg::CH_LOWER_L, 1'b0);
          queue_byte(stscan_pkg::CH_LOWER_S, 1'b0);
          queue_byte(stscan_pkg::CH_LOWER_E, 1'b0);
        end
        default: begin
          queue_byte(stscan_pkg::CH_LOWER_V, 1'b0);
          queue_byte(stscan_pkg::CH_LOWER_A, 1'b0);
          queue_byte(stscan_pkg::CH_LOWER_R, 1'b0);
        end
      endcase
      // A trailing word character turns the keyword back into a plain name.
      if ($urandom_range(0, 2) == 0)
        queue_byte(word_char(), 1'b0);
    end else if (pick < 35) begin
      lead_dot = ($urandom_range(0, 3) == 0);
      if (lead_dot)
        queue_byte(stscan_pkg::CH_DOT, 1'b0);
      n = token_len();
      for (i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(0, 4) == 0)
          queue_byte(stscan_pkg::CH_DOT, 1'b0);
        else
          queue_byte(8'(stscan_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0);
      end
    end else if (pick < 45) begin
      queue_byte(stscan_pkg::CH_QUOTE, 1'b0);
      n = token_len() - 1;
      for (i = 0; i < n; i++) begin
        c = 8'($urandom_range(0, 255));
        queue_byte((c == stscan_pkg::CH_QUOTE) ? stscan_pkg::CH_QMARK : c, 1'b0);
      end
      if ($urandom_range(0, 9) != 0)
        queue_byte(stscan_pkg::CH_QUOTE, 1'b0);
    end else if (pick < 60) begin
      case ($urandom_range(0, 8))
        0:       queue_byte(stscan_pkg::CH_PLUS, 1'b0);
        1:       queue_byte(stscan_pkg::CH_MINUS, 1'b0);
        2:       queue_byte(stscan_pkg::CH_STAR, 1'b0);
        3:       queue_byte(stscan_pkg::CH_SLASH, 1'b0);
        4:       queue_byte(stscan_pkg::CH_LPAREN, 1'b0);
        5:       queue_byte(stscan_pkg::CH_RPAREN, 1'b0);
        6:       queue_byte(stscan_pkg::CH_LBRACE, 1'b0);
        7:       queue_byte(stscan_pkg::CH_RBRACE, 1'b0);
        default: queue_byte(stscan_pkg::CH_SEMI, 1'b0);
      endcase
    end else if (pick < 67) begin
      queue_byte(stscan_pkg::CH_EQUALS, 1'b0);
      if ($urandom_range(0, 1) == 0)
        queue_byte(stscan_pkg::CH_EQUALS, 1'b0);
    end else if (pick < 72) begin
      queue_byte(stscan_pkg::CH_DOT, 1'b0);
    end else if (pick < 80) begin
      queue_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 95) begin
      n = $urandom_range(0, 5);
      if (n == 5)
        queue_byte(stscan_pkg::CH_SPACE, 1'b0);
      else
        queue_byte(8'(stscan_pkg::CH_TAB + n), 1'b0);
    end else begin
      queue_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endfunction

  // Offer one request until the block takes it; the sender may idle at any cycle.
  task automatic offer_request(logic [7:0] b, logic e);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < send_idle_pct) begin
        push = 1'b0;
      end else begin
        push        = 1'b1;
        source_byte = b;
        end_marker  = e;
      end
      @(posedge clk);
      if (push && !full) begin
        sb.note_request(b, e);
        taken = 1'b1;
      end
    end
  endtask

  task automatic send_queued();
    source_item_t it;
    while (source_q.size() != 0) begin
      it = source_q.pop_front();
      offer_request(it.b, it.e);
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n_items);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (source_q.size() < n_items)
      queue_token();
    send_queued();
  endtask

  // Main sequence: reset, directed source, random phases, pressure, then drain.
  initial begin
    string directed;
    int    i;
    rst         = 1'b1;
    push        = 1'b0;
    source_byte = 8'h00;
    end_marker  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Keyword, every operator, equality then assignment, a lone dot, a number that
    // starts with a dot, an empty string, a high unknown byte, a tab, and an
    // unterminated string flushed by the end of the source.
    directed = "var+-*/(){};===.x.5\"\"";
    for (i = 0; i < directed.len(); i++)
      queue_byte(directed[i], 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(stscan_pkg::CH_TAB, 1'b0);
    queue_byte(stscan_pkg::CH_QUOTE, 1'b0);
    queue_byte(stscan_pkg::CH_LOWER_A, 1'b0);
    queue_byte(8'h00, 1'b1);
    send_queued();

    run_phase(0, 0, 56);
    run_phase(70, 0, 56);
    run_phase(0, 70, 56);
    run_phase(24, 24, 56);

    // Output held off for a long stretch while the input keeps pushing.
    hold_request = 1'b1;
    run_phase(0, 0, 56);
    queue_byte(8'h00, 1'b1);
    send_queued();
    @(negedge clk);
    push = 1'b0;

    while (sb.expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("** script_token_scanner_unit: PASSED **");
    end else begin
      $display("** script_token_scanner_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/stscan_pkg.sv
rtl/stscan_front.sv
rtl/stscan_cmdq.sv
rtl/stscan_back.sv
rtl/script_token_scanner_unit.sv
bench/tb_script_token_scanner_unit.sv
